### rtl/core/pbcl_pkg.sv
package pbcl_pkg;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_WARNING_LEVEL     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNLIMITED_CEILING = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_CEILING      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTRA_CEILING     = 2'd3;

   localparam logic [15:0] WARNING_LEVEL_RESET     = 16'd30;
   localparam logic [15:0] UNLIMITED_CEILING_RESET = 16'd4000;
   localparam logic [15:0] BASE_CEILING_RESET      = 16'd4000;
   localparam logic [15:0] EXTRA_CEILING_RESET     = 16'd1000;

   localparam logic [15:0] CAP_NONE     = 16'hFFFF;
   localparam logic [15:0] FLOOR_ENERGY = 16'd5;

   // Which rule sets the limit for a transaction.
   localparam int MODE_W = 3;
   localparam logic [MODE_W-1:0] MODE_UNLIMITED  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LOW_ENERGY = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DERATE     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_HEADROOM   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_OVER_CAP   = 3'd4;

   // Divider geometry. Both divisions have a numerator below 2^40 and a
   // quotient below 2^27, so the top 13 numerator bits start below the divisor.
   localparam int NUM_W      = 40;
   localparam int DEN_W      = 16;
   localparam int REM_W      = DEN_W + 1;
   localparam int QUO_W      = 27;
   localparam int DIV_BITS   = 3;
   localparam int DIV_STAGES = QUO_W / DIV_BITS;
   localparam int LIM_W      = QUO_W;

   // Edges from an accepted request to the edge that takes its result.
   localparam int LATENCY = DIV_STAGES + 4;

   typedef struct packed {
      logic signed [15:0] command_value;
      logic [15:0]        power_cap;
      logic [15:0]        stored_energy;
      logic [23:0]        measured_power;
   } req_type;

   typedef struct packed {
      logic signed [15:0] limited_command;
      logic               was_clamped;
      logic [15:0]        applied_ceiling;
   } rsp_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [15:0]       command;
   } side_type;

endpackage

### rtl/core/pbcl_div_pipe.sv
module pbcl_div_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_vld,
   input  logic [pbcl_pkg::NUM_W-1:0]    in_num,
   input  logic [pbcl_pkg::DEN_W-1:0]    in_den,
   input  pbcl_pkg::side_type            in_side,
   output logic                          out_vld,
   output logic [pbcl_pkg::QUO_W-1:0]    out_quo,
   output pbcl_pkg::side_type            out_side
);

   localparam int STAGES = pbcl_pkg::DIV_STAGES;
   localparam int QW     = pbcl_pkg::QUO_W;
   localparam int DW     = pbcl_pkg::DEN_W;
   localparam int RW     = pbcl_pkg::REM_W;

   logic                 vld_ff  [STAGES];
   logic [DW-1:0]        rem_ff  [STAGES];
   logic [QW-1:0]        low_ff  [STAGES];
   logic [QW-1:0]        quo_ff  [STAGES];
   logic [DW-1:0]        den_ff  [STAGES];
   pbcl_pkg::side_type   side_ff [STAGES];

   logic [DW-1:0]        rem_in  [STAGES];
   logic [QW-1:0]        low_in  [STAGES];
   logic [QW-1:0]        quo_in  [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic                src_vld;
      logic [DW-1:0]       src_rem;
      logic [QW-1:0]       src_low;
      logic [QW-1:0]       src_quo;
      logic [DW-1:0]       src_den;
      pbcl_pkg::side_type  src_side;

      if (s == 0) begin : g_first
         // The bits above the quotient range form the starting remainder.
         assign src_vld  = in_vld;
         assign src_rem  = DW'(in_num[pbcl_pkg::NUM_W-1:QW]);
         assign src_low  = in_num[QW-1:0];
         assign src_quo  = '0;
         assign src_den  = in_den;
         assign src_side = in_side;
      end else begin : g_next
         assign src_vld  = vld_ff[s-1];
         assign src_rem  = rem_ff[s-1];
         assign src_low  = low_ff[s-1];
         assign src_quo  = quo_ff[s-1];
         assign src_den  = den_ff[s-1];
         assign src_side = side_ff[s-1];
      end

      always_comb begin : c_steps
         logic [RW-1:0] trial;
         logic [DW-1:0] r;
         logic [QW-1:0] lo;
         logic [QW-1:0] q;
         r  = src_rem;
         lo = src_low;
         q  = src_quo;
         for (int k = 0; k < pbcl_pkg::DIV_BITS; k++) begin
            trial = {r, lo[QW-1]};
            lo    = {lo[QW-2:0], 1'b0};
            if (trial >= {1'b0, src_den}) begin
               trial = trial - {1'b0, src_den};
               q     = {q[QW-2:0], 1'b1};
            end else begin
               q     = {q[QW-2:0], 1'b0};
            end
            r = trial[DW-1:0];
         end
         rem_in[s] = r;
         low_in[s] = lo;
         quo_in[s] = q;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= src_vld;
         end
         rem_ff[s]  <= rem_in[s];
         low_ff[s]  <= low_in[s];
         quo_ff[s]  <= quo_in[s];
         den_ff[s]  <= src_den;
         side_ff[s] <= src_side;
      end
   end

   assign out_vld  = vld_ff[STAGES-1];
   assign out_quo  = quo_ff[STAGES-1];
   assign out_side = side_ff[STAGES-1];

endmodule

### rtl/core/power_budget_current_limiter.sv
// Power-budget current limiter. A request is taken on any clock edge with start high and
// busy low; busy is high only while reset is asserted, so a new request may be issued in
// every cycle. Each request produces exactly one result, shown on rsp_data for a single
// cycle with rsp_valid high. The edge that takes a request loads the first of thirteen
// register stages (two input stages, nine stages of the shared radix-8 divider, two
// output stages). Each result is shown on rsp_data once; the receiver must take it then,
// as results cannot be held back. Register writes on the csr_ port are always ready and
// must only be made while no requests are in flight.
module power_budget_current_limiter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  pbcl_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   output pbcl_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pbcl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [15:0]                       csr_wdata
);

   localparam int LW = pbcl_pkg::LIM_W;

   logic [15:0] warning_level_ff;
   logic [15:0] unlimited_ceiling_ff;
   logic [15:0] base_ceiling_ff;
   logic [15:0] extra_ceiling_ff;

   logic accept;

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         warning_level_ff     <= pbcl_pkg::WARNING_LEVEL_RESET;
         unlimited_ceiling_ff <= pbcl_pkg::UNLIMITED_CEILING_RESET;
         base_ceiling_ff      <= pbcl_pkg::BASE_CEILING_RESET;
         extra_ceiling_ff     <= pbcl_pkg::EXTRA_CEILING_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pbcl_pkg::CSR_WARNING_LEVEL:     warning_level_ff     <= csr_wdata;
            pbcl_pkg::CSR_UNLIMITED_CEILING: unlimited_ceiling_ff <= csr_wdata;
            pbcl_pkg::CSR_BASE_CEILING:      base_ceiling_ff      <= csr_wdata;
            pbcl_pkg::CSR_EXTRA_CEILING:     extra_ceiling_ff     <= csr_wdata;
         endcase
      end
   end

   // Stage 1: pick the rule and the multiplier and divider operands.
   logic                 s1_vld_ff;
   pbcl_pkg::side_type   s1_side_ff,  s1_side_in;
   logic [15:0]          s1_mul_a_ff, s1_mul_a_in;
   logic [21:0]          s1_mul_b_ff, s1_mul_b_in;
   logic [15:0]          s1_den_ff,   s1_den_in;

   always_comb begin : c_stage1
      logic [23:0] c192;
      logic [23:0] c256;
      logic [15:0] floor_buf;
      logic [21:0] headroom;
      c256      = {req_data.power_cap, 8'h00};
      c192      = 24'({req_data.power_cap, 7'h00}) + 24'({req_data.power_cap, 6'h00});
      floor_buf = (req_data.stored_energy > pbcl_pkg::FLOOR_ENERGY) ?
                  req_data.stored_energy : pbcl_pkg::FLOOR_ENERGY;
      // Only meaningful when derating, where it stays below 64 times the cap.
      headroom  = 22'(c256 - req_data.measured_power);

      s1_side_in.command = req_data.command_value;
      priority if (req_data.power_cap == 16'd0 ||
                   req_data.power_cap == pbcl_pkg::CAP_NONE) begin
         s1_side_in.mode = pbcl_pkg::MODE_UNLIMITED;
      end else if (req_data.stored_energy < warning_level_ff) begin
         s1_side_in.mode = pbcl_pkg::MODE_LOW_ENERGY;
      end else if (req_data.measured_power <= c192) begin
         s1_side_in.mode = pbcl_pkg::MODE_HEADROOM;
      end else if (req_data.measured_power < c256) begin
         s1_side_in.mode = pbcl_pkg::MODE_DERATE;
      end else begin
         s1_side_in.mode = pbcl_pkg::MODE_OVER_CAP;
      end

      if (s1_side_in.mode == pbcl_pkg::MODE_LOW_ENERGY) begin
         s1_mul_a_in = base_ceiling_ff;
         s1_mul_b_in = 22'(floor_buf);
         s1_den_in   = warning_level_ff;
      end else begin
         s1_mul_a_in = extra_ceiling_ff;
         s1_mul_b_in = headroom;
         s1_den_in   = req_data.power_cap;
      end
   end

   // Stage 2: the product that forms the numerator.
   logic                 s2_vld_ff;
   pbcl_pkg::side_type   s2_side_ff;
   logic [37:0]          s2_prod_ff;
   logic [15:0]          s2_den_ff;
   logic [pbcl_pkg::NUM_W-1:0] div_num;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
         s2_vld_ff <= s1_vld_ff;
      end
      s1_side_ff  <= s1_side_in;
      s1_mul_a_ff <= s1_mul_a_in;
      s1_mul_b_ff <= s1_mul_b_in;
      s1_den_ff   <= s1_den_in;
      s2_side_ff  <= s1_side_ff;
      s2_prod_ff  <= 38'(s1_mul_a_ff) * 38'(s1_mul_b_ff);
      s2_den_ff   <= s1_den_ff;
   end

   // Low energy scales by 256, derating by 4; both fit in 40 bits.
   assign div_num = (s2_side_ff.mode == pbcl_pkg::MODE_LOW_ENERGY) ?
                    {s2_prod_ff[31:0], 8'h00} : {s2_prod_ff, 2'b00};

   logic                        dv_vld;
   logic [pbcl_pkg::QUO_W-1:0]  dv_quo;
   pbcl_pkg::side_type          dv_side;

   pbcl_div_pipe u_div (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (s2_vld_ff),
      .in_num   (div_num),
      .in_den   (s2_den_ff),
      .in_side  (s2_side_ff),
      .out_vld  (dv_vld),
      .out_quo  (dv_quo),
      .out_side (dv_side)
   );

   // Limit stage: the Q19.8 limit for the chosen rule.
   logic                 lim_vld_ff;
   pbcl_pkg::side_type   lim_side_ff;
   logic [LW-1:0]        lim_ff, lim_in;

   always_comb begin
      unique case (dv_side.mode)
         pbcl_pkg::MODE_UNLIMITED:  lim_in = LW'({unlimited_ceiling_ff, 8'h00});
         pbcl_pkg::MODE_LOW_ENERGY: lim_in = dv_quo;
         pbcl_pkg::MODE_DERATE:     lim_in = LW'({base_ceiling_ff, 8'h00}) + dv_quo;
         pbcl_pkg::MODE_HEADROOM:   lim_in = LW'({base_ceiling_ff, 8'h00}) +
                                             LW'({extra_ceiling_ff, 8'h00});
         default:                   lim_in = LW'({base_ceiling_ff, 8'h00});
      endcase
   end

   // Output stage: clamp against the exact Q19.8 limit.
   logic              rsp_valid_ff;
   pbcl_pkg::rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin : c_clamp
      logic [15:0]    cmd;
      logic           neg;
      logic [16:0]    mag;
      logic [LW-9:0]  lim_int;
      logic           clamp;
      cmd     = lim_side_ff.command;
      neg     = cmd[15];
      mag     = neg ? (17'd0 - {1'b1, cmd}) : {1'b0, cmd};
      lim_int = lim_ff[LW-1:8];
      clamp   = LW'({mag, 8'h00}) > lim_ff;

      rsp_data_in.was_clamped     = clamp;
      rsp_data_in.applied_ceiling = (|lim_int[LW-9:16]) ? 16'hFFFF : lim_int[15:0];
      if (clamp) begin
         rsp_data_in.limited_command = neg ? (16'd0 - lim_int[15:0]) : lim_int[15:0];
      end else begin
         rsp_data_in.limited_command = cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lim_vld_ff   <= dv_vld;
         rsp_valid_ff <= lim_vld_ff;
      end
      lim_side_ff <= dv_side;
      lim_ff      <= lim_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/core/pbcl_checker.sv
module pbcl_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input pbcl_pkg::req_type                 req_data,
   input logic                              rsp_valid,
   input pbcl_pkg::rsp_type                 rsp_data,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [pbcl_pkg::CSR_IDX_W-1:0]    csr_index,
   input logic [15:0]                       csr_wdata
);

   logic accept;
   logic cfg_write;

   assign accept    = start && !busy;
   assign cfg_write = csr_valid && csr_ready && (csr_index == csr_index) &&
                      (csr_wdata == csr_wdata);

   // Each request yields a result, unchecked during CSR writes; nothing else does.
   a_result_follows: assert property (@(posedge clock) disable iff (reset || cfg_write)
      accept |-> ##(pbcl_pkg::LATENCY) rsp_valid)
      else $error("no result at the expected latency");

   a_no_stray_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, pbcl_pkg::LATENCY))
      else $error("result without a matching request");

   // An unclamped command passes through untouched.
   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.was_clamped |->
         rsp_data.limited_command == $past(req_data.command_value, pbcl_pkg::LATENCY))
      else $error("unclamped command was altered");

   // A clamped command carries the reported ceiling with the original sign.
   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.was_clamped |->
         (!$past(req_data.command_value[15], pbcl_pkg::LATENCY) &&
          rsp_data.limited_command == rsp_data.applied_ceiling) ||
         ($past(req_data.command_value[15], pbcl_pkg::LATENCY) &&
          rsp_data.limited_command == 16'(16'd0 - rsp_data.applied_ceiling)))
      else $error("clamped command does not match the ceiling");

endmodule

bind power_budget_current_limiter pbcl_checker u_pbcl_checker (.*);

### tb/tb_top.sv
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 60;

   typedef struct {
      pbcl_pkg::req_type req;
      int unsigned       gap;
   } pending_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   pbcl_pkg::req_type req_data = '0;
   logic              rsp_valid;
   pbcl_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [pbcl_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // Local copy of the register file, kept in step with accepted writes.
   logic [15:0] cfg_warning_level     = pbcl_pkg::WARNING_LEVEL_RESET;
   logic [15:0] cfg_unlimited_ceiling = pbcl_pkg::UNLIMITED_CEILING_RESET;
   logic [15:0] cfg_base_ceiling      = pbcl_pkg::BASE_CEILING_RESET;
   logic [15:0] cfg_extra_ceiling     = pbcl_pkg::EXTRA_CEILING_RESET;

   pending_type       pending_commands[$];
   pbcl_pkg::rsp_type expected_limits[$];
   pbcl_pkg::rsp_type expected_rsp;
   int unsigned       gap_count = 0;
   int unsigned       cycle_count = 0;
   bit                failed = 1'b0;

   power_budget_current_limiter uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // Works out the clamped command and the reported ceiling from the local registers.
   function automatic pbcl_pkg::rsp_type limit_command(input pbcl_pkg::req_type r);
      logic [63:0] warn, base_q, extra, cap, energy, pwr, c256, c192, lim, lim_int, mag;
      logic [15:0] li;
      logic        neg;
      pbcl_pkg::rsp_type o;
      warn   = {48'd0, cfg_warning_level};
      base_q = {48'd0, cfg_base_ceiling} << 8;
      extra  = {48'd0, cfg_extra_ceiling};
      cap    = {48'd0, r.power_cap};
      energy = {48'd0, r.stored_energy};
      pwr    = {40'd0, r.measured_power};
      if (r.power_cap == 16'd0 || r.power_cap == pbcl_pkg::CAP_NONE) begin
         lim = {48'd0, cfg_unlimited_ceiling} << 8;
      end else if (energy < warn && warn != 64'd0) begin
         if (energy < {48'd0, pbcl_pkg::FLOOR_ENERGY}) energy = {48'd0, pbcl_pkg::FLOOR_ENERGY};
         lim = ({48'd0, cfg_base_ceiling} * energy * 64'd256) / warn;
      end else begin
         c256 = cap * 64'd256;
         c192 = cap * 64'd192;
         if (pwr > c192) begin
            if (pwr < c256) lim = base_q + (64'd4 * extra * (c256 - pwr)) / cap;
            else lim = base_q;
         end else begin
            lim = base_q + (extra << 8);
         end
      end
      lim_int = lim >> 8;
      neg = r.command_value[15];
      mag = neg ? (64'd65536 - {48'd0, r.command_value}) : {48'd0, r.command_value};
      o.limited_command = r.command_value;
      o.was_clamped = 1'b0;
      if ((mag << 8) > lim) begin
         li = lim_int[15:0];
         o.was_clamped = 1'b1;
         o.limited_command = neg ? (16'd0 - li) : li;
      end
      o.applied_ceiling = (lim_int > 64'hFFFF) ? 16'hFFFF : lim_int[15:0];
      return o;
   endfunction

   function automatic pbcl_pkg::req_type make_request(input logic [15:0] cmd,
                                                      input logic [15:0] cap,
                                                      input logic [15:0] energy,
                                                      input logic [23:0] pwr);
      pbcl_pkg::req_type r;
      r.command_value  = cmd;
      r.power_cap      = cap;
      r.stored_energy  = energy;
      r.measured_power = pwr;
      return r;
   endfunction

   // Random transaction, steered towards each way of setting the limit.
   function automatic pbcl_pkg::req_type random_request();
      pbcl_pkg::req_type r;
      pbcl_pkg::rsp_type probe;
      int unsigned       cap, pwr;
      int                m;
      bit                neg;
      case ($urandom_range(0, 9))
         0: cap = 0;
         1: cap = 65535;
         2: cap = $urandom_range(1, 10);
         3: cap = 65534;
         default: cap = $urandom_range(1, 65534);
      endcase
      r.power_cap = 16'(cap);
      if (cfg_warning_level != 16'd0 && $urandom_range(0, 2) == 0)
         r.stored_energy = 16'($urandom_range(0, cfg_warning_level - 1));
      else if ($urandom_range(0, 3) == 0)
         r.stored_energy = cfg_warning_level;
      else
         r.stored_energy = 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 4))
         0: pwr = $urandom_range(0, 192 * cap);
         1: pwr = (cap > 0) ? $urandom_range(192 * cap + 1, 256 * cap - 1) : 0;
         2: pwr = $urandom_range(256 * cap, 24'hFFFFFF);
         3: pwr = 192 * cap + $urandom_range(0, 1);
         default: pwr = $urandom_range(0, 24'hFFFFFF);
      endcase
      r.measured_power = 24'(pwr);
      r.command_value = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 2) == 0) begin
         // Put the command right at the edge of the ceiling.
         probe = limit_command(r);
         m = int'(probe.applied_ceiling) + int'($urandom_range(0, 2)) - 1;
         if (m < 0) m = 0;
         if (m > 32768) m = 32768;
         neg = ($urandom_range(0, 1) == 1) || (m > 32767);
         r.command_value = neg ? 16'(-m) : 16'(m);
      end
      return r;
   endfunction

   task automatic queue_request(input pbcl_pkg::req_type r, input int unsigned gap);
      pending_type p;
      p.req = r;
      p.gap = gap;
      pending_commands.push_back(p);
   endtask

   task automatic write_reg(input logic [pbcl_pkg::CSR_IDX_W-1:0] idx,
                            input logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         pbcl_pkg::CSR_WARNING_LEVEL:     cfg_warning_level = val;
         pbcl_pkg::CSR_UNLIMITED_CEILING: cfg_unlimited_ceiling = val;
         pbcl_pkg::CSR_BASE_CEILING:      cfg_base_ceiling = val;
         pbcl_pkg::CSR_EXTRA_CEILING:     cfg_extra_ceiling = val;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_commands.size() != 0 || start || expected_limits.size() != 0);
      repeat (pbcl_pkg::LATENCY + 2) @(posedge clock);
   endtask

   task automatic run_phase(input logic [15:0] warn, input logic [15:0] unl,
                            input logic [15:0] base, input logic [15:0] extra,
                            input int style);
      int unsigned gap;
      write_reg(pbcl_pkg::CSR_WARNING_LEVEL, warn);
      write_reg(pbcl_pkg::CSR_UNLIMITED_CEILING, unl);
      write_reg(pbcl_pkg::CSR_BASE_CEILING, base);
      write_reg(pbcl_pkg::CSR_EXTRA_CEILING, extra);
      @(negedge clock);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         case (style)
            0: gap = 0;
            1: gap = $urandom_range(0, 17);
            default: gap = ((i / 12) % 2 == 1) ? $urandom_range(0, 17) : 0;
         endcase
         queue_request(random_request(), gap);
      end
      wait_idle();
   endtask

   // Driver: sends the queued transactions and records what each one should produce.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) expected_limits.push_back(limit_command(req_data));
         if (!start || !busy) begin
            if (pending_commands.size() != 0 && gap_count >= pending_commands[0].gap) begin
               req_data <= pending_commands[0].req;
               start <= 1'b1;
               void'(pending_commands.pop_front());
               gap_count = 0;
            end else begin
               start <= 1'b0;
               if (pending_commands.size() != 0) gap_count++;
            end
         end
      end
   end

   // Monitor: every result is taken in the cycle it is shown.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_limits.size() == 0) begin
            $error("result with nothing expected: %p", rsp_data);
            failed = 1'b1;
         end else begin
            expected_rsp = expected_limits.pop_front();
            if (rsp_data.limited_command !== expected_rsp.limited_command) begin
               $error("limited_command: expected %0d, got %0d",
                      expected_rsp.limited_command, rsp_data.limited_command);
               failed = 1'b1;
            end
            if (rsp_data.was_clamped !== expected_rsp.was_clamped) begin
               $error("was_clamped: expected %0d, got %0d",
                      expected_rsp.was_clamped, rsp_data.was_clamped);
               failed = 1'b1;
            end
            if (rsp_data.applied_ceiling !== expected_rsp.applied_ceiling) begin
               $error("applied_ceiling: expected %0d, got %0d",
                      expected_rsp.applied_ceiling, rsp_data.applied_ceiling);
               failed = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed transactions against the reset values of the registers.
      queue_request(make_request(16'sd32767, 16'd0, 16'd100, 24'd0), 0);
      queue_request(make_request(-16'sd32768, 16'hFFFF, 16'd100, 24'hFFFFFF), 0);
      queue_request(make_request(16'sd4000, 16'd0, 16'd0, 24'd0), 1);
      queue_request(make_request(16'sd4001, 16'hFFFF, 16'd0, 24'd0), 0);
      queue_request(make_request(-16'sd4000, 16'd0, 16'd0, 24'd0), 3);
      queue_request(make_request(-16'sd4001, 16'd0, 16'd0, 24'd0), 0);
      queue_request(make_request(16'sd0, 16'd100, 16'd0, 24'd0), 17);
      queue_request(make_request(-16'sd1, 16'd100, 16'd4, 24'd0), 0);
      queue_request(make_request(16'sd32767, 16'd100, 16'd5, 24'd0), 2);
      queue_request(make_request(-16'sd32768, 16'd100, 16'd29, 24'd0), 0);
      queue_request(make_request(16'sd32767, 16'd100, 16'd30, 24'd19200), 0);
      queue_request(make_request(16'sd32767, 16'd100, 16'd30, 24'd19201), 5);
      queue_request(make_request(-16'sd32768, 16'd100, 16'hFFFF, 24'd22000), 0);
      queue_request(make_request(16'sd32767, 16'd100, 16'hFFFF, 24'd25599), 0);
      queue_request(make_request(16'sd32767, 16'd100, 16'hFFFF, 24'd25600), 0);
      queue_request(make_request(-16'sd32768, 16'd100, 16'd1000, 24'hFFFFFF), 9);
      queue_request(make_request(16'sd5000, 16'd1, 16'd1000, 24'd193), 0);
      queue_request(make_request(16'sd5000, 16'hFFFE, 16'd1000, 24'hFFFFFF), 0);
      queue_request(make_request(16'sd5000, 16'hFFFE, 16'd1000, 24'd0), 0);
      queue_request(make_request(16'sd4999, 16'd100, 16'd1000, 24'd0), 0);
      queue_request(make_request(16'sd5001, 16'd100, 16'd1000, 24'd0), 4);
      queue_request(make_request(16'h5555, 16'hAAAA, 16'h5555, 24'hAAAAAA), 0);
      queue_request(make_request(16'hAAAA, 16'h5555, 16'hAAAA, 24'h555555), 0);
      wait_idle();

      run_phase(16'd0, 16'd0, 16'd0, 16'd0, 1);
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
      run_phase(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2);
      run_phase(16'd5, 16'd0, 16'd300, 16'd7, 1);
      run_phase(pbcl_pkg::WARNING_LEVEL_RESET, pbcl_pkg::UNLIMITED_CEILING_RESET,
                pbcl_pkg::BASE_CEILING_RESET, pbcl_pkg::EXTRA_CEILING_RESET, 2);
      for (int p = 0; p < 3; p++) begin
         run_phase(($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 6))
                                               : 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), $urandom_range(0, 2));
      end

      if (expected_limits.size() != 0) begin
         $error("%0d results never arrived", expected_limits.size());
         failed = 1'b1;
      end
      if (!failed) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### power_budget_current_limiter.f
rtl/core/pbcl_pkg.sv
rtl/core/pbcl_div_pipe.sv
rtl/core/power_budget_current_limiter.sv
rtl/core/pbcl_checker.sv
tb/tb_top.sv
